/* sv/sed_pkg.sv */
// sed_pkg: shared types and constants for the sonar echo detector
// no dependencies; used by sed_tracker, sed_calc and sonar_echo_detector_unit
`default_nettype none

package sed_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned STREN_W  = 13;
	localparam int unsigned DIST_W   = 25;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// configuration register indexes
	localparam logic REG_THRESHOLD  = 1'b0;
	localparam logic REG_MAX_ECHOES = 1'b1;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 16'd0;
	localparam logic [INDEX_W-1:0]  MAX_ECHOES_RST = 8'd20;

	// floor(w / 13) = (w * ceil(2^20 / 13)) >> 20, exact for all 16 bit w
	localparam int unsigned         RECIP_SHIFT = 20;
	localparam logic [16:0]         RECIP13     = 17'd80660;

	// distance in 0.01 mm per tick: 343 * 25e-6 / 2 * 1e5 = 1715 / 4
	localparam int unsigned         DIST_SHIFT  = 2;
	localparam logic signed [27:0]  DIST_MUL    = 28'sd1715;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [TIME_W-1:0]  start;
		logic [TIME_W-1:0]  stop;
		logic [TIME_W-1:0]  burst_start;
	} echo_t;

endpackage

`default_nettype wire

/* sv/sed_tracker.sv */
// sed_tracker: burst and echo state tracking, config registers, first pipeline stage
// depends on sed_pkg
`default_nettype none

module sed_tracker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_index,
	input  wire logic [sed_pkg::SAMPLE_W-1:0]  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [sed_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [sed_pkg::TIME_W-1:0]    time_stamp,
	output logic                               valid_s1,
	input  wire logic                          ready_s2,
	output sed_pkg::echo_t                     echo_s1
);

	logic [sed_pkg::SAMPLE_W-1:0] threshold_q;
	logic [sed_pkg::INDEX_W-1:0]  max_echoes_q;
	logic                         burst_active_q;
	logic                         burst_done_q;
	logic                         in_echo_q;
	logic [sed_pkg::TIME_W-1:0]   burst_start_q;
	logic [sed_pkg::TIME_W-1:0]   echo_start_q;
	logic [sed_pkg::INDEX_W-1:0]  echo_count_q;

	logic in_fire;
	logic above;
	logic below;
	logic is_clear;
	logic echo_ends;
	logic emit;

	assign in_ready  = !valid_s1 || ready_s2;
	assign in_fire   = in_valid && in_ready;
	assign is_clear  = (op == sed_pkg::OP_CLEAR);
	assign above     = sample > threshold_q;
	assign below     = sample < threshold_q;
	assign echo_ends = !is_clear && burst_done_q && in_echo_q && below;
	assign emit      = echo_ends && (echo_count_q < max_echoes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= sed_pkg::THRESHOLD_RST;
			max_echoes_q <= sed_pkg::MAX_ECHOES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sed_pkg::REG_THRESHOLD:  threshold_q  <= cfg_wdata;
				sed_pkg::REG_MAX_ECHOES: max_echoes_q <= cfg_wdata[sed_pkg::INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_active_q <= 1'b0;
			burst_done_q   <= 1'b0;
			in_echo_q      <= 1'b0;
			burst_start_q  <= '0;
			echo_start_q   <= '0;
			echo_count_q   <= '0;
		end else if (in_fire) begin
			if (is_clear) begin
				burst_active_q <= 1'b0;
				burst_done_q   <= 1'b0;
				in_echo_q      <= 1'b0;
				burst_start_q  <= '0;
				echo_start_q   <= '0;
				echo_count_q   <= '0;
			end else if (!burst_done_q) begin
				if (!burst_active_q && above) begin
					burst_active_q <= 1'b1;
					burst_start_q  <= time_stamp;
				end else if (burst_active_q && below) begin
					burst_done_q <= 1'b1;
				end
			end else if (!in_echo_q && above) begin
				in_echo_q    <= 1'b1;
				echo_start_q <= time_stamp;
			end else if (echo_ends) begin
				in_echo_q <= 1'b0;
				if (emit) begin
					echo_count_q <= echo_count_q + 8'd1;
				end
			end
		end
	end

	// stage 1: echo that has just ended, waiting for the arithmetic stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			echo_s1.index       <= echo_count_q;
			echo_s1.start       <= echo_start_q;
			echo_s1.stop        <= time_stamp;
			echo_s1.burst_start <= burst_start_q;
		end
	end

	a_echo_after_burst : assert property (@(posedge clk) disable iff (!arst_n)
		in_echo_q |-> burst_done_q)
		else $error("echo tracked before burst ended");

	a_done_implies_active : assert property (@(posedge clk) disable iff (!arst_n)
		burst_done_q |-> burst_active_q)
		else $error("burst done without burst start");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && emit) |=> (echo_count_q == $past(echo_count_q) + 8'd1))
		else $error("echo count did not advance on reported echo");

	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(echo_s1)))
		else $error("stage 1 transaction lost while stalled");

endmodule

`default_nettype wire

/* sv/sed_calc.sv */
// sed_calc: strength, time of flight and distance, result register
// depends on sed_pkg
`default_nettype none

module sed_calc (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              valid_s1,
	output logic                                   ready_s2,
	input  wire sed_pkg::echo_t                    echo_s1,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [sed_pkg::INDEX_W-1:0]            echo_index,
	output logic [sed_pkg::TIME_W-1:0]             echo_start,
	output logic [sed_pkg::TIME_W-1:0]             echo_end,
	output logic [sed_pkg::STREN_W-1:0]            strength,
	output logic signed [sed_pkg::TIME_W-1:0]      time_of_flight,
	output logic signed [sed_pkg::DIST_W-1:0]      distance
);

	logic [sed_pkg::TIME_W-1:0]        width;
	logic [32:0]                       recip_prod;
	logic [sed_pkg::STREN_W-1:0]       stren_nxt;
	logic signed [sed_pkg::TIME_W-1:0] tof_nxt;
	logic signed [27:0]                tof_ext;
	logic signed [27:0]                dist_prod;

	assign ready_s2 = !out_valid || out_ready;

	always_comb begin
		width      = echo_s1.stop - echo_s1.start;
		recip_prod = 33'(width) * 33'(sed_pkg::RECIP13);
		stren_nxt  = recip_prod[32:sed_pkg::RECIP_SHIFT] + 13'd1;
		tof_nxt    = $signed(echo_s1.stop - echo_s1.burst_start);
		tof_ext    = 28'(tof_nxt);
		dist_prod  = tof_ext * sed_pkg::DIST_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			echo_index     <= echo_s1.index;
			echo_start     <= echo_s1.start;
			echo_end       <= echo_s1.stop;
			strength       <= stren_nxt;
			time_of_flight <= tof_nxt;
			distance       <= dist_prod[sed_pkg::DIST_W+sed_pkg::DIST_SHIFT-1:sed_pkg::DIST_SHIFT];
		end
	end

endmodule

`default_nettype wire

/* sv/sonar_echo_detector_unit.sv */
// sonar_echo_detector_unit: top level of the sonar echo detector
// depends on sed_pkg, sed_tracker and sed_calc
// One transaction is accepted per clock cycle when the result side keeps up.
// The first sample above the threshold opens the transmit burst and the next
// sample below it closes it; each later rise above and fall below the
// threshold is an echo, and the sample that ends it yields one result via the
// tracking stage and then the multiplier stage: index, start and end
// stamps, strength, time of flight from the burst start and distance in
// 0.01 mm. Samples equal to the threshold change nothing, op = 1 clears the
// measurement, echoes past max_echoes are dropped, and the user must write
// configuration only while no transaction is in flight; it is not enforced.
`default_nettype none

module sonar_echo_detector_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_index,
	input  wire logic [sed_pkg::SAMPLE_W-1:0]      cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              op,
	input  wire logic [sed_pkg::SAMPLE_W-1:0]      sample,
	input  wire logic [sed_pkg::TIME_W-1:0]        time_stamp,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [sed_pkg::INDEX_W-1:0]            echo_index,
	output logic [sed_pkg::TIME_W-1:0]             echo_start,
	output logic [sed_pkg::TIME_W-1:0]             echo_end,
	output logic [sed_pkg::STREN_W-1:0]            strength,
	output logic signed [sed_pkg::TIME_W-1:0]      time_of_flight,
	output logic signed [sed_pkg::DIST_W-1:0]      distance
);

	logic           valid_s1;
	logic           ready_s2;
	sed_pkg::echo_t echo_s1;

	sed_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.sample     (sample),
		.time_stamp (time_stamp),
		.valid_s1   (valid_s1),
		.ready_s2   (ready_s2),
		.echo_s1    (echo_s1)
	);

	sed_calc u_calc (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.ready_s2       (ready_s2),
		.echo_s1        (echo_s1),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.echo_index     (echo_index),
		.echo_start     (echo_start),
		.echo_end       (echo_end),
		.strength       (strength),
		.time_of_flight (time_of_flight),
		.distance       (distance)
	);

endmodule

`default_nettype wire
